// ----- design/chunked_body_deframer_defines.svh -----
// ----------------------------------------------------------------------------
// Chunked body deframer assertion macros
// Shared property forms for the checker that watches the top level ports.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_BODY_DEFRAMER_DEFINES_SVH
`define CHUNKED_BODY_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define CBD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is low.
`define CBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cbd_pkg.sv -----
// ----------------------------------------------------------------------------
// Chunked body deframer package
// Shared types, codes and byte classifiers for the deframer.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int COUNT_BITS = 32;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [7:0]            byte_t;
  typedef logic [2:0]            status_t;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_EARLY    = 3'd1;
  localparam status_t ST_BAD_LINE = 3'd2;
  localparam status_t ST_NO_CRLF  = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;

  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_SPACE = 8'h20;

  typedef enum logic [6:0] {
    PH_LEAD    = 7'b0000001,
    PH_DIGITS  = 7'b0000010,
    PH_EXT     = 7'b0000100,
    PH_DATA    = 7'b0001000,
    PH_DATA_CR = 7'b0010000,
    PH_DATA_LF = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic    valid;
    logic    is_status;
    byte_t   payload;
    status_t code;
  } result_t;

  function automatic logic is_ws(input byte_t c);
    is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_hex(input byte_t c);
    is_hex = ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "f")) ||
             ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [3:0] hex_val(input byte_t c);
    byte_t v;
    v = 8'd0;
    if ((c >= "0") && (c <= "9")) begin
      v = c - 8'h30;
    end else if ((c >= "a") && (c <= "f")) begin
      v = c - 8'h57;
    end else if ((c >= "A") && (c <= "F")) begin
      v = c - 8'h37;
    end
    hex_val = v[3:0];
  endfunction

endpackage

// ----- design/cbd_core.sv -----
// ----------------------------------------------------------------------------
// Chunked body deframer decode core
// Holds the framing state and decodes one registered word per fire.
// ----------------------------------------------------------------------------
module cbd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  cbd_pkg::byte_t  body_byte,
  input  logic            end_marker,
  output cbd_pkg::result_t res
);

  cbd_pkg::phase_t phase_r, phase_nxt;
  logic            pcr_r, pcr_nxt;
  cbd_pkg::count_t cnt_r, cnt_nxt;

  always_comb begin
    cbd_pkg::result_t r;
    logic             stat;
    cbd_pkg::status_t code;
    r         = '0;
    stat      = 1'b0;
    code      = cbd_pkg::ST_OK;
    phase_nxt = phase_r;
    pcr_nxt   = pcr_r;
    cnt_nxt   = cnt_r;
    if (fire) begin
      if (end_marker) begin
        if (phase_r != cbd_pkg::PH_DONE) begin
          stat = 1'b1;
          code = cbd_pkg::ST_EARLY;
        end
      end else begin
        case (phase_r)
          cbd_pkg::PH_LEAD: begin
            if ((body_byte == cbd_pkg::CH_LF) && pcr_r) begin
              stat = 1'b1;
              code = cbd_pkg::ST_BAD_LINE;
            end else if (cbd_pkg::is_ws(body_byte)) begin
              pcr_nxt = (body_byte == cbd_pkg::CH_CR);
            end else if (!cbd_pkg::is_hex(body_byte)) begin
              stat = 1'b1;
              code = cbd_pkg::ST_BAD_LINE;
            end else begin
              cnt_nxt   = cbd_pkg::count_t'(cbd_pkg::hex_val(body_byte));
              pcr_nxt   = 1'b0;
              phase_nxt = cbd_pkg::PH_DIGITS;
            end
          end
          cbd_pkg::PH_DIGITS: begin
            if (cbd_pkg::is_hex(body_byte)) begin
              if (cnt_r[cbd_pkg::COUNT_BITS-1 -: 4] != 4'd0) begin
                stat = 1'b1;
                code = cbd_pkg::ST_OVERFLOW;
              end else begin
                cnt_nxt = {cnt_r[cbd_pkg::COUNT_BITS-5:0], cbd_pkg::hex_val(body_byte)};
              end
            end else begin
              phase_nxt = cbd_pkg::PH_EXT;
              pcr_nxt   = (body_byte == cbd_pkg::CH_CR);
            end
          end
          cbd_pkg::PH_EXT: begin
            if ((body_byte == cbd_pkg::CH_LF) && pcr_r) begin
              pcr_nxt = 1'b0;
              if (cnt_r == '0) begin
                stat = 1'b1;
                code = cbd_pkg::ST_OK;
              end else begin
                phase_nxt = cbd_pkg::PH_DATA;
              end
            end else begin
              pcr_nxt = (body_byte == cbd_pkg::CH_CR);
            end
          end
          cbd_pkg::PH_DATA: begin
            r.valid   = 1'b1;
            r.payload = body_byte;
            cnt_nxt   = cnt_r - cbd_pkg::count_t'(1);
            if (cnt_r == cbd_pkg::count_t'(1)) begin
              phase_nxt = cbd_pkg::PH_DATA_CR;
            end
          end
          cbd_pkg::PH_DATA_CR: begin
            if (body_byte != cbd_pkg::CH_CR) begin
              stat = 1'b1;
              code = cbd_pkg::ST_NO_CRLF;
            end else begin
              phase_nxt = cbd_pkg::PH_DATA_LF;
            end
          end
          cbd_pkg::PH_DATA_LF: begin
            if (body_byte != cbd_pkg::CH_LF) begin
              stat = 1'b1;
              code = cbd_pkg::ST_NO_CRLF;
            end else begin
              phase_nxt = cbd_pkg::PH_LEAD;
              pcr_nxt   = 1'b0;
            end
          end
          default: begin
            // done: drop bytes until the end marker
          end
        endcase
      end
      if (stat) begin
        r.valid     = 1'b1;
        r.is_status = 1'b1;
        r.payload   = 8'd0;
        r.code      = code;
        phase_nxt   = cbd_pkg::PH_DONE;
        pcr_nxt     = 1'b0;
      end
      // end marker rearms for the next body
      if (end_marker) begin
        phase_nxt = cbd_pkg::PH_LEAD;
        pcr_nxt   = 1'b0;
        cnt_nxt   = '0;
      end
    end
    res = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cbd_pkg::PH_LEAD;
      pcr_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pcr_r   <= pcr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- design/chunked_body_deframer.sv -----
// ----------------------------------------------------------------------------
// Chunked body deframer
// Strips HTTP/1.1 chunked framing from a byte stream and reports status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per accepted cycle, either
//   a raw body byte (in_end_marker low) or an end marker that closes the body
//   and rearms the block for the next one.
//   Output channel (out_valid / out_stall): a payload byte (out_is_status low)
//   or one final status (out_is_status high, out_status: 0 ok, 1 ended
//   early, 2 bad size line, 3 missing CR LF after data, 4 size overflow).
//   Bytes after a status are dropped with no result until the end marker.
//   Path: an accepted word waits in the input register and its result is
//   registered in the result register; one input register and one result
//   register bracket a single decode step. Throughput: one word per cycle
//   unless stalled, set by the framing state update in the decode core.
//   Stall: while out_stall holds a full result register, the input register
//   stays full and in_stall rises in the same cycle; no word is lost.
//   Reset (rst_n low, synchronous): both registers empty, framing state back
//   to the start of a size line with a zero count.
// ----------------------------------------------------------------------------
module chunked_body_deframer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_body_byte,
  input  logic                   in_end_marker,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_is_status,
  output logic [7:0]             out_payload_byte,
  output logic [2:0]             out_status
);

  logic             iv_r;
  cbd_pkg::byte_t   ibyte_r;
  logic             iend_r;
  logic             advance;
  logic             fire;
  cbd_pkg::result_t res;
  cbd_pkg::result_t out_r;

  // result register can take a new value when empty or being drained
  assign advance  = !out_r.valid || !out_stall;
  assign fire     = iv_r && advance;
  assign in_stall = iv_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (!in_stall) begin
      iv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ibyte_r <= in_body_byte;
      iend_r  <= in_end_marker;
    end
  end

  cbd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .body_byte  (ibyte_r),
    .end_marker (iend_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_r.valid;
  assign out_is_status    = out_r.is_status;
  assign out_payload_byte = out_r.payload;
  assign out_status       = out_r.code;

endmodule

// ----- design/cbd_checker.sv -----
// ----------------------------------------------------------------------------
// Chunked body deframer port checker
// Watches the top level ports for result coding and handshake slips.
// ----------------------------------------------------------------------------
`include "chunked_body_deframer_defines.svh"

module cbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_is_status,
  input logic [7:0] out_payload_byte,
  input logic [2:0] out_status
);

  `CBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_is_status) && $stable(out_payload_byte) && $stable(out_status),
    "stalled result word changed")

  `CBD_ASSERT_SAME(a_payload_code, out_valid && !out_is_status,
    out_status == cbd_pkg::ST_OK, "payload word carries a status code")

  `CBD_ASSERT_SAME(a_status_word, out_valid && out_is_status,
    (out_payload_byte == 8'd0) && (out_status <= cbd_pkg::ST_OVERFLOW),
    "status word malformed")

  `CBD_ASSERT_SAME(a_reset_empty, $past(!rst_n),
    !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind chunked_body_deframer cbd_checker u_cbd_checker (.*);
